// File: rtl/assert_macros.svh
// Assertion macros for the corner detector RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MCD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mcd_pkg.sv
// Shared types, constants and window functions of the corner detector.
// Depends on nothing.
package mcd_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int unsigned LINES = 4;

    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_BINARIZE_LEVEL = 2'd2;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [15:0] RST_HEIGHT = 16'd480;
    localparam logic [8:0]  RST_LEVEL  = 9'h1FF;

    localparam logic [7:0] PIX_MAX = 8'd255;
    localparam logic [7:0] PIX_MIN = 8'd0;

    typedef logic [7:0] pix_t;
    typedef logic [4:0][4:0][7:0] win_t;
    typedef logic [4:0][7:0] rowval_t;
    typedef logic [4:0] mask_t;

    typedef enum logic [1:0] {
        SHAPE_CROSS   = 2'd0,
        SHAPE_X       = 2'd1,
        SHAPE_DIAMOND = 2'd2,
        SHAPE_SQUARE  = 2'd3
    } shape_t;

    typedef struct packed {
        mask_t             row1_ok;
        mask_t             col1_ok;
        mask_t             row2_ok;
        mask_t             col2_ok;
        logic              emit;
        logic              row_end;
        logic              frame_end;
        logic signed [8:0] level;
    } tick_info_t;

    function automatic logic in_shape(shape_t s, int i, int j);
        int   ay;
        int   ax;
        logic hit;
        ay = (i >= 2) ? (i - 2) : (2 - i);
        ax = (j >= 2) ? (j - 2) : (2 - j);
        case (s)
            SHAPE_CROSS:   hit = (ay == 0) || (ax == 0);
            SHAPE_X:       hit = (ay == ax);
            SHAPE_DIAMOND: hit = (ay + ax) <= 2;
            default:       hit = 1'b1;
        endcase
        return hit;
    endfunction

    function automatic pix_t win_max(win_t w, mask_t rok, mask_t cok, shape_t s);
        pix_t m;
        m = PIX_MIN;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (in_shape(s, i, j) && rok[i] && cok[j] && (w[i][j] > m)) begin
                    m = w[i][j];
                end
            end
        end
        return m;
    endfunction

    function automatic rowval_t row_min(win_t w, mask_t rok, mask_t cok, shape_t s);
        rowval_t r;
        for (int i = 0; i < 5; i++) begin
            r[i] = PIX_MAX;
            for (int j = 0; j < 5; j++) begin
                if (in_shape(s, i, j) && rok[i] && cok[j] && (w[i][j] < r[i])) begin
                    r[i] = w[i][j];
                end
            end
        end
        return r;
    endfunction

    function automatic pix_t min5(rowval_t r);
        pix_t m;
        m = r[0];
        for (int i = 1; i < 5; i++) begin
            if (r[i] < m) begin
                m = r[i];
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/morphological_corner_detector.sv
// Top level of the 5x5 morphological corner detector.
// Depends on mcd_pkg, mcd_ctrl, mcd_line_window and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, req_type, pixel_value) takes one frame in
//   raster order, then drain ticks (req_type = 1). Output channel (out_valid/
//   out_stall) gives corner_value with row_end and frame_end flags.
//   Configuration is written over cfg_write/cfg_index/cfg_data, by the user only
//   while idle (the block does not enforce this), and latched at a frame's
//   first pixel. Throughput: one item per clock. The whole datapath is one
//   pipeline with a common advance enable, so a result can be taken in the
//   same cycle a new item enters.
//   Latency: in items, the result for pixel n comes with advancing item
//   n + 4*W + 4 (W = frame width), set by the two four-line buffers.
//   Each item passes both buffers' input and window registers, then s5 and output.
//   Reset clears all control state and sets the configuration registers to their
//   defaults; line memory contents stay as they were and are masked at the frame
//   borders. When the receiver stalls with a result waiting, the pipeline holds
//   and in_stall rises; nothing is lost or repeated.
`include "assert_macros.svh"

module morphological_corner_detector
    import mcd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  pixel_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  corner_value,
    output logic        row_end,
    output logic        frame_end
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    logic          adv;
    logic          acc;
    logic          go;
    logic [CW-1:0] col;
    tick_info_t    info;

    logic          s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    tick_info_t    s1_info_reg, s2_info_reg, s3_info_reg, s4_info_reg;
    logic [CW-1:0] s1_col_reg, s2_col_reg;

    win_t [0:0]    src_win;
    win_t [1:0]    dil_win;
    logic [1:0][7:0] dil_data;

    rowval_t       rm_a, rm_b;
    rowval_t       s5_rm_a_reg, s5_rm_b_reg;
    logic          s5_re_reg, s5_fe_reg;
    logic signed [8:0] s5_level_reg;

    pix_t          ero_a, ero_b, diff, corner_next;

    logic          out_valid_reg;
    pix_t          corner_reg;
    logic          row_end_reg, frame_end_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    mcd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .req_type  (req_type),
        .go        (go),
        .col       (col),
        .info      (info)
    );

    mcd_line_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .LANES     (1)
    ) u_src_lines (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (go),
        .in_col  (col),
        .in_data (pixel_value),
        .win     (src_win)
    );

    assign dil_data[0] = win_max(src_win[0], s2_info_reg.row1_ok, s2_info_reg.col1_ok,
                                 SHAPE_CROSS);
    assign dil_data[1] = win_max(src_win[0], s2_info_reg.row1_ok, s2_info_reg.col1_ok,
                                 SHAPE_X);

    mcd_line_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .LANES     (2)
    ) u_dil_lines (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (s2_v_reg),
        .in_col  (s2_col_reg),
        .in_data (dil_data),
        .win     (dil_win)
    );

    assign rm_a = row_min(dil_win[0], s4_info_reg.row2_ok, s4_info_reg.col2_ok, SHAPE_DIAMOND);
    assign rm_b = row_min(dil_win[1], s4_info_reg.row2_ok, s4_info_reg.col2_ok, SHAPE_SQUARE);

    always_comb
    begin
        ero_a = min5(s5_rm_a_reg);
        ero_b = min5(s5_rm_b_reg);
        diff  = (ero_a > ero_b) ? (ero_a - ero_b) : (ero_b - ero_a);
        if (s5_level_reg > 9'sd0)
        begin
            corner_next = ($signed({1'b0, diff}) > s5_level_reg) ? PIX_MAX : PIX_MIN;
        end
        else
        begin
            corner_next = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg      <= go;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg && s4_info_reg.emit;
            out_valid_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_info_reg   <= info;
            s1_col_reg    <= col;
            s2_info_reg   <= s1_info_reg;
            s2_col_reg    <= s1_col_reg;
            s3_info_reg   <= s2_info_reg;
            s4_info_reg   <= s3_info_reg;
            s5_rm_a_reg   <= rm_a;
            s5_rm_b_reg   <= rm_b;
            s5_re_reg     <= s4_info_reg.row_end;
            s5_fe_reg     <= s4_info_reg.frame_end;
            s5_level_reg  <= s4_info_reg.level;
            corner_reg    <= corner_next;
            row_end_reg   <= s5_re_reg;
            frame_end_reg <= s5_fe_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign corner_value = corner_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;

    `MCD_ASSERT_NOW(a_fe_has_re, out_valid_reg && frame_end_reg, row_end_reg, "frame_end without row_end")
    `MCD_ASSERT_NEXT(a_s1_to_s2, adv && s1_v_reg, s2_v_reg, "item lost between stages 1 and 2")
    `MCD_ASSERT_NEXT(a_emit_out, adv && s4_v_reg && s4_info_reg.emit, s5_v_reg, "result lost after erosion")

endmodule

// File: rtl/mcd_ctrl.sv
// Configuration registers, frame sequencing and border masks per item.
// Depends on mcd_pkg.
module mcd_ctrl
    import mcd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          acc,
    input  logic                          req_type,
    output logic                          go,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output tick_info_t                    info
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    logic [10:0]   width_reg;
    logic [15:0]   height_reg;
    logic [8:0]    level_reg;

    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic [10:0]   fw_reg, fw_next;
    logic [15:0]   fh_reg, fh_next;
    logic [8:0]    thr_reg, thr_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   irow_reg, irow_next;
    logic [12:0]   lead_reg, lead_next;
    logic [16:0]   r1_reg, r1_next;
    logic [CW-1:0] c1_reg, c1_next;
    logic [15:0]   r2_reg, r2_next;
    logic [CW-1:0] c2_reg, c2_next;

    logic          start;
    logic [10:0]   wclamp;
    logic [15:0]   hclamp;
    logic [10:0]   w;
    logic [15:0]   h;
    logic [CW-1:0] ccol, cc1, cc2;
    logic [15:0]   cirow, cr2;
    logic [16:0]   cr1;
    logic [12:0]   clead, d1, d2;
    logic          cdone;
    logic          emit1, emit2;
    logic          col_last, c1_last, re, fe;

    always_comb
    begin
        start = !active_reg && !req_type;
        go    = acc && (start || (active_reg && (done_reg || !req_type)));

        if (width_reg == 11'd0)
        begin
            wclamp = 11'd1;
        end
        else if (int'(width_reg) > int'(MAX_WIDTH))
        begin
            wclamp = 11'(MAX_WIDTH);
        end
        else
        begin
            wclamp = width_reg;
        end
        hclamp = (height_reg == 16'd0) ? 16'd1 : height_reg;

        w     = start ? wclamp : fw_reg;
        h     = start ? hclamp : fh_reg;
        ccol  = start ? '0 : col_reg;
        cirow = start ? '0 : irow_reg;
        cdone = start ? 1'b0 : done_reg;
        clead = start ? '0 : lead_reg;
        cr1   = start ? '0 : r1_reg;
        cc1   = start ? '0 : c1_reg;
        cr2   = start ? '0 : r2_reg;
        cc2   = start ? '0 : c2_reg;

        d1    = 13'({w, 1'b0}) + 13'd2;
        d2    = 13'({w, 2'b00}) + 13'd4;
        emit1 = clead >= d1;
        emit2 = clead >= d2;

        col_last = (32'(ccol) + 32'd1) >= 32'(w);
        c1_last  = (32'(cc1) + 32'd1) >= 32'(w);
        re       = (32'(cc2) + 32'd1) >= 32'(w);
        fe       = re && ((32'(cr2) + 32'd1) >= 32'(h));

        col = ccol;

        info.row1_ok[0] = cr1 >= 17'd2;
        info.row1_ok[1] = cr1 >= 17'd1;
        info.row1_ok[2] = 32'(cr1) < 32'(h);
        info.row1_ok[3] = (32'(cr1) + 32'd1) < 32'(h);
        info.row1_ok[4] = (32'(cr1) + 32'd2) < 32'(h);
        info.col1_ok[0] = 32'(cc1) >= 32'd2;
        info.col1_ok[1] = 32'(cc1) >= 32'd1;
        info.col1_ok[2] = 32'(cc1) < 32'(w);
        info.col1_ok[3] = (32'(cc1) + 32'd1) < 32'(w);
        info.col1_ok[4] = (32'(cc1) + 32'd2) < 32'(w);
        info.row2_ok[0] = cr2 >= 16'd2;
        info.row2_ok[1] = cr2 >= 16'd1;
        info.row2_ok[2] = 32'(cr2) < 32'(h);
        info.row2_ok[3] = (32'(cr2) + 32'd1) < 32'(h);
        info.row2_ok[4] = (32'(cr2) + 32'd2) < 32'(h);
        info.col2_ok[0] = 32'(cc2) >= 32'd2;
        info.col2_ok[1] = 32'(cc2) >= 32'd1;
        info.col2_ok[2] = 32'(cc2) < 32'(w);
        info.col2_ok[3] = (32'(cc2) + 32'd1) < 32'(w);
        info.col2_ok[4] = (32'(cc2) + 32'd2) < 32'(w);
        info.emit       = emit2;
        info.row_end    = re;
        info.frame_end  = fe;
        info.level      = start ? level_reg : thr_reg;

        fw_next   = w;
        fh_next   = h;
        thr_next  = start ? level_reg : thr_reg;
        col_next  = col_last ? '0 : CW'(32'(ccol) + 32'd1);
        irow_next = cirow;
        done_next = cdone;
        if (!cdone && col_last)
        begin
            irow_next = cirow + 16'd1;
            if ((32'(cirow) + 32'd1) >= 32'(h))
            begin
                done_next = 1'b1;
            end
        end
        lead_next = (clead < d2) ? (clead + 13'd1) : clead;

        r1_next = cr1;
        c1_next = cc1;
        if (emit1)
        begin
            if (c1_last)
            begin
                c1_next = '0;
                r1_next = cr1 + 17'd1;
            end
            else
            begin
                c1_next = CW'(32'(cc1) + 32'd1);
            end
        end

        r2_next = cr2;
        c2_next = cc2;
        if (emit2)
        begin
            if (re)
            begin
                c2_next = '0;
                r2_next = cr2 + 16'd1;
            end
            else
            begin
                c2_next = CW'(32'(cc2) + 32'd1);
            end
        end

        active_next = !(emit2 && fe);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            level_reg  <= RST_LEVEL;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            fw_reg     <= 11'd1;
            fh_reg     <= 16'd1;
            thr_reg    <= '0;
            col_reg    <= '0;
            irow_reg   <= '0;
            lead_reg   <= '0;
            r1_reg     <= '0;
            c1_reg     <= '0;
            r2_reg     <= '0;
            c2_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:    width_reg  <= cfg_data[10:0];
                    REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                    REG_BINARIZE_LEVEL: level_reg  <= cfg_data[8:0];
                    default:            ;
                endcase
            end
            if (go)
            begin
                active_reg <= active_next;
                done_reg   <= done_next;
                fw_reg     <= fw_next;
                fh_reg     <= fh_next;
                thr_reg    <= thr_next;
                col_reg    <= col_next;
                irow_reg   <= irow_next;
                lead_reg   <= lead_next;
                r1_reg     <= r1_next;
                c1_reg     <= c1_next;
                r2_reg     <= r2_next;
                c2_reg     <= c2_next;
            end
        end
    end

endmodule

// File: rtl/mcd_line_window.sv
// Four-line buffer memory with a 5x5 sliding window per lane.
// Depends on mcd_pkg.
module mcd_line_window
    import mcd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int unsigned LANES     = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_v,
    input  logic [$clog2(MAX_WIDTH)-1:0]  in_col,
    input  logic [LANES-1:0][7:0]         in_data,
    output win_t [LANES-1:0]              win
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    logic [LINES-1:0][LANES-1:0][7:0] mem [MAX_WIDTH];

    logic                             a_v_reg;
    logic [CW-1:0]                    a_col_reg;
    logic [LANES-1:0][7:0]            a_data_reg;
    logic [LINES-1:0][LANES-1:0][7:0] rd_reg;
    logic                             byp_reg;
    logic [LINES-1:0][LANES-1:0][7:0] byp_word_reg;
    win_t [LANES-1:0]                 win_reg;

    logic [LINES-1:0][LANES-1:0][7:0] eff;
    logic [LINES:0][LANES-1:0][7:0]   newcol;
    logic [LINES-1:0][LANES-1:0][7:0] wr_word;

    always_comb
    begin
        eff       = byp_reg ? byp_word_reg : rd_reg;
        newcol[0] = a_data_reg;
        for (int k = 1; k <= LINES; k++)
        begin
            newcol[k] = eff[k-1];
        end
        for (int k = 0; k < LINES; k++)
        begin
            wr_word[k] = newcol[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_col_reg    <= in_col;
            a_data_reg   <= in_data;
            rd_reg       <= mem[in_col];
            byp_reg      <= a_v_reg && (a_col_reg == in_col);
            byp_word_reg <= wr_word;
        end
        if (adv && a_v_reg)
        begin
            mem[a_col_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_v_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                for (int r = 0; r < 5; r++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        win_reg[l][r][j] <= win_reg[l][r][j+1];
                    end
                    win_reg[l][r][4] <= newcol[4-r][l];
                end
            end
        end
    end

    assign win = win_reg;

endmodule
